FILE: rtl/spicd_pkg.sv
`timescale 1ns / 1ps

package spicd_pkg;

  // Field widths of the request and the result
  localparam int BUS_W = 28;
  localparam int TGT_W = 32;
  localparam int PRE_W = 13;
  localparam int CNT_W = 6;

  // Divider chain limits
  localparam int PRESCALE_MAX_DEF = 8191;
  localparam int COUNT_MAX_DEF    = 63;

  localparam logic [BUS_W-1:0] BUS_RESET = BUS_W'(80000000);

endpackage

FILE: rtl/spi_clock_divider_search.sv
`timescale 1ns / 1ps
// Throughput: one request at a time; the next is taken once this one's result is loaded
// into the output register. One shared bit-serial divider serves every division.
// Reset (rst, synchronous) returns the engine to idle, drops out_valid and sets
// bus_hz to 80 MHz.
module spi_clock_divider_search #(
  parameter int PRESCALE_MAX = spicd_pkg::PRESCALE_MAX_DEF,
  parameter int COUNT_MAX    = spicd_pkg::COUNT_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [spicd_pkg::BUS_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [spicd_pkg::TGT_W-1:0] target_hz,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        bypass,
  output logic [spicd_pkg::PRE_W-1:0] prescale,
  output logic [spicd_pkg::CNT_W-1:0] count_n,
  output logic [spicd_pkg::CNT_W-1:0] count_low,
  output logic [spicd_pkg::BUS_W-1:0] achieved_hz
);
  import spicd_pkg::*;

  localparam int PW  = $clog2(PRESCALE_MAX + 1);
  localparam int PW1 = $clog2(PRESCALE_MAX + 2);
  localparam int CW  = $clog2(COUNT_MAX + 1);
  localparam int CW1 = $clog2(COUNT_MAX + 2);
  localparam int DVW = CW1 + TGT_W;
  localparam logic [DVW-1:0] SLOW_DIV = DVW'((PRESCALE_MAX + 1) * (COUNT_MAX + 1));
  localparam logic [BUS_W:0] GUESS_HI = (BUS_W + 1)'(PRESCALE_MAX + 2);
  localparam logic [BUS_W:0] GUESS_OFS = (BUS_W + 1)'(2);

  typedef enum logic [3:0] {
    S_IDLE, S_SLOW_GO, S_SLOW_WAIT, S_EST_SET, S_EST_GO, S_EST_WAIT,
    S_CAND_SET, S_CAND_MUL, S_CAND_GO, S_CAND_WAIT, S_WRAP, S_FIN
  } state_t;

  state_t            state;
  logic [BUS_W-1:0]  bus_hz;
  logic [TGT_W-1:0]  tgt;
  logic [CW-1:0]     n;
  logic [1:0]        k;
  logic [BUS_W-1:0]  q_est;
  logic [PW-1:0]     pre;
  logic [DVW-1:0]    dvs;
  logic [PW-1:0]     best_pre;
  logic [CW-1:0]     best_n;
  logic [BUS_W-1:0]  best_hz;
  logic              r_byp;
  logic [PW-1:0]     r_pre;
  logic [CW-1:0]     r_n;
  logic [CW-1:0]     r_low;
  logic [BUS_W-1:0]  r_hz;

  logic              div_start;
  logic              div_done;
  logic [BUS_W-1:0]  div_q;
  logic [TGT_W-1:0]  div_q_x;
  logic [CW1-1:0]    n1;
  logic [CW1-1:0]    best_n1;
  logic [PW1-1:0]    pre1;
  logic [BUS_W:0]    guess;
  logic [PW-1:0]     pre_clamp;
  logic              hit;
  logic              better;

  assign in_stall  = rst || (state != S_IDLE);
  assign div_start = (state == S_SLOW_GO) || (state == S_EST_GO) || (state == S_CAND_GO);
  assign div_q_x   = TGT_W'(div_q);
  assign n1        = CW1'(n) + 1'b1;
  assign best_n1   = CW1'(best_n) + 1'b1;
  assign pre1      = PW1'(pre) + 1'b1;
  assign guess     = (BUS_W + 1)'(q_est) + (BUS_W + 1)'(k);
  assign hit       = (div_q_x == tgt);
  assign better    = (div_q_x < tgt) && (div_q > best_hz);

  // prescale guess is the quotient minus two plus k, clamped to the legal range
  always_comb begin
    if (guess <= GUESS_OFS) begin
      pre_clamp = '0;
    end else if (guess > GUESS_HI) begin
      pre_clamp = PW'(PRESCALE_MAX);
    end else begin
      pre_clamp = PW'(guess - GUESS_OFS);
    end
  end

  spicd_div #(.DVW(DVW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (bus_hz),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_hz <= BUS_RESET;
    end else if (cfg_wr_en) begin
      bus_hz <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            tgt <= target_hz;
            if (target_hz >= TGT_W'(bus_hz)) begin
              r_byp <= 1'b1;
              r_pre <= '0;
              r_n   <= '0;
              r_low <= '0;
              r_hz  <= bus_hz;
              state <= S_FIN;
            end else begin
              dvs   <= SLOW_DIV;
              state <= S_SLOW_GO;
            end
          end
        end
        S_SLOW_GO: state <= S_SLOW_WAIT;
        S_SLOW_WAIT: begin
          if (div_done) begin
            if ((tgt < div_q_x) || (tgt == '0)) begin
              r_byp <= 1'b0;
              r_pre <= PW'(PRESCALE_MAX);
              r_n   <= CW'(COUNT_MAX);
              r_low <= '0;
              r_hz  <= div_q;
              state <= S_FIN;
            end else begin
              n        <= CW'(1);
              best_pre <= '0;
              best_n   <= '0;
              best_hz  <= '0;
              state    <= S_EST_SET;
            end
          end
        end
        S_EST_SET: begin
          // (bus / (n+1)) / target folds into one division by (n+1) * target
          dvs   <= DVW'(n1 * tgt);
          state <= S_EST_GO;
        end
        S_EST_GO: state <= S_EST_WAIT;
        S_EST_WAIT: begin
          if (div_done) begin
            q_est <= div_q;
            k     <= '0;
            state <= S_CAND_SET;
          end
        end
        S_CAND_SET: begin
          pre   <= pre_clamp;
          state <= S_CAND_MUL;
        end
        S_CAND_MUL: begin
          dvs   <= DVW'(pre1 * n1);
          state <= S_CAND_GO;
        end
        S_CAND_GO: state <= S_CAND_WAIT;
        S_CAND_WAIT: begin
          if (div_done) begin
            if (hit) begin
              best_pre <= pre;
              best_n   <= n;
              best_hz  <= div_q;
              state    <= S_WRAP;
            end else begin
              if (better) begin
                best_pre <= pre;
                best_n   <= n;
                best_hz  <= div_q;
              end
              if (k == 2'd3) begin
                if (n == CW'(COUNT_MAX)) begin
                  state <= S_WRAP;
                end else begin
                  n     <= n + 1'b1;
                  state <= S_EST_SET;
                end
              end else begin
                k     <= k + 1'b1;
                state <= S_CAND_SET;
              end
            end
          end
        end
        S_WRAP: begin
          // no candidate at or below the request leaves the undivided bus clock
          r_byp <= 1'b0;
          r_pre <= best_pre;
          r_n   <= best_n;
          r_low <= CW'(best_n1 >> 1);
          r_hz  <= (best_hz == '0) ? bus_hz : best_hz;
          state <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            bypass      <= r_byp;
            prescale    <= PRE_W'(r_pre);
            count_n     <= CNT_W'(r_n);
            count_low   <= CNT_W'(r_low);
            achieved_hz <= r_hz;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/spicd_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Dividend is the bus clock.
module spicd_div #(
  parameter int DVW = 39
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [spicd_pkg::BUS_W-1:0] dividend,
  input  logic [DVW-1:0]             divisor,
  output logic                       done,
  output logic [spicd_pkg::BUS_W-1:0] quotient
);
  import spicd_pkg::*;

  localparam int CW = $clog2(BUS_W);
  localparam logic [CW-1:0] LAST = CW'(BUS_W - 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [BUS_W-1:0]  dsh;
  logic [BUS_W-1:0]  rem;
  logic [DVW-1:0]    dvs;

  logic [BUS_W:0]    trial;
  logic [DVW-1:0]    trial_x;
  logic              ge;
  logic [BUS_W-1:0]  rem_next;

  assign trial   = {rem, dsh[BUS_W-1]};
  assign trial_x = DVW'(trial);
  assign ge      = (trial_x >= dvs);
  assign rem_next = ge ? BUS_W'(trial_x - dvs) : trial[BUS_W-1:0];
  assign quotient = dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dsh  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        // shift the next dividend bit into the remainder, the quotient bit in at the bottom
        dsh <= {dsh[BUS_W-2:0], ge};
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/spicd_chk.sv
`timescale 1ns / 1ps

module spicd_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        bypass,
  input logic [spicd_pkg::PRE_W-1:0] prescale,
  input logic [spicd_pkg::CNT_W-1:0] count_n,
  input logic [spicd_pkg::CNT_W-1:0] count_low,
  input logic [spicd_pkg::BUS_W-1:0] achieved_hz
);
  import spicd_pkg::*;

  logic [CNT_W:0] half_n;
  assign half_n = ({1'b0, count_n} + 1'b1) >> 1;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable({bypass, prescale, count_n, count_low, achieved_hz}))
    else $error("result changed while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in flight");

  a_bypass_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bypass |-> (prescale == '0) && (count_n == '0) && (count_low == '0))
    else $error("bypass result carries divider settings");

  a_low_half: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bypass && (count_low != '0) |-> count_low == CNT_W'(half_n))
    else $error("low count is not half the count");

endmodule

bind spi_clock_divider_search spicd_chk u_spicd_chk (.*);

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import spicd_pkg::*;

  localparam int PMAX        = PRESCALE_MAX_DEF;
  localparam int CMAX        = COUNT_MAX_DEF;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int SETTLE      = 40;

  typedef struct packed {
    logic             bypass;
    logic [PRE_W-1:0] prescale;
    logic [CNT_W-1:0] count_n;
    logic [CNT_W-1:0] count_low;
    logic [BUS_W-1:0] achieved_hz;
  } divider_setting_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;
  typedef enum int {TGT_EXACT, TGT_SPREAD, TGT_WIDE, TGT_BELOW, TGT_NEAR_BUS} target_kind_e;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [BUS_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [TGT_W-1:0] target_hz = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             bypass;
  logic [PRE_W-1:0] prescale;
  logic [CNT_W-1:0] count_n;
  logic [CNT_W-1:0] count_low;
  logic [BUS_W-1:0] achieved_hz;

  divider_setting_t expected_settings[$];
  logic [BUS_W-1:0] bus_clock_model = BUS_RESET;
  bit               valid_held = 1'b0;
  int               burst_left = 0;
  int               requests_sent = 0;
  int               settings_checked = 0;
  int               mismatch_count = 0;
  int               bus_settings = 1;
  int               cycle_count = 0;

  int               hold_requests = 0;
  int               hold_taken = 0;
  int               hold_len = 0;
  int               hold_left = 0;
  stall_mode_e      stall_mode = STALL_NONE;
  int               phase_left = 0;

  spi_clock_divider_search u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .target_hz   (target_hz),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bypass      (bypass),
    .prescale    (prescale),
    .count_n     (count_n),
    .count_low   (count_low),
    .achieved_hz (achieved_hz)
  );

  always #6 clk = ~clk;

  function automatic longint unsigned chain_rate(input longint unsigned bus,
                                                 input longint unsigned pre,
                                                 input longint unsigned n);
    return bus / ((pre + 1) * (n + 1));
  endfunction

  function automatic divider_setting_t predict_divider_setting(input logic [TGT_W-1:0] tgt,
                                                               input logic [BUS_W-1:0] bus);
    divider_setting_t r;
    longint unsigned  b, t, slowest, hz, best_hz, best_pre, best_n, pre;
    longint           est, guess;
    bit               exact;
    r = '0;
    b = bus;
    t = tgt;
    if (t >= b) begin
      r.bypass = 1'b1;
      r.achieved_hz = bus;
      return r;
    end
    slowest = chain_rate(b, PMAX, CMAX);
    if (t < slowest || t == 0) begin
      r.prescale    = PRE_W'(PMAX);
      r.count_n     = CNT_W'(CMAX);
      r.achieved_hz = BUS_W'(slowest);
      return r;
    end
    best_hz  = 0;
    best_pre = 0;
    best_n   = 0;
    exact    = 1'b0;
    for (int n = 1; n <= CMAX && !exact; n++) begin
      est = longint'((b / (n + 1)) / t) - 1;
      // try four prescale guesses around the estimate
      for (int v = -1; v <= 2 && !exact; v++) begin
        guess = est + v;
        if (guess > PMAX) pre = PMAX;
        else if (guess <= 0) pre = 0;
        else pre = guess;
        hz = chain_rate(b, pre, n);
        if (hz == t) begin
          best_pre = pre;
          best_n   = n;
          exact    = 1'b1;
        end else if (hz < t && (t - hz) < (t - best_hz)) begin
          best_hz  = hz;
          best_pre = pre;
          best_n   = n;
        end
      end
    end
    r.prescale    = PRE_W'(best_pre);
    r.count_n     = CNT_W'(best_n);
    r.count_low   = CNT_W'((best_n + 1) / 2);
    r.achieved_hz = BUS_W'(chain_rate(b, best_pre, best_n));
    return r;
  endfunction

  function automatic logic [TGT_W-1:0] pick_target(input logic [BUS_W-1:0] bus);
    longint unsigned b, slowest, k, t;
    target_kind_e    kind;
    int unsigned     roll;
    b = bus;
    slowest = chain_rate(b, PMAX, CMAX);
    roll = $urandom_range(0, 9);
    case (roll)
      0, 1, 2, 3: kind = TGT_EXACT;
      4, 5, 6:    kind = TGT_SPREAD;
      7:          kind = TGT_WIDE;
      8:          kind = TGT_BELOW;
      default:    kind = TGT_NEAR_BUS;
    endcase
    case (kind)
      TGT_EXACT: begin
        // land on or next to a rate the chain can make
        k = ($urandom_range(0, $urandom_range(0, 1) ? 63 : PMAX) + 1) *
            ($urandom_range(1, CMAX) + 1);
        t = b / k + $urandom_range(0, 2);
      end
      TGT_SPREAD:   t = (b >> $urandom_range(1, 20)) + $urandom_range(0, 255);
      TGT_WIDE:     t = $urandom;
      TGT_BELOW:    t = (slowest == 0) ? 0 : $urandom_range(0, 32'(slowest - 1));
      default:      t = (b > 2) ? b - $urandom_range(0, 2) : b;
    endcase
    return t[TGT_W-1:0];
  endfunction

  task automatic send_request(input logic [TGT_W-1:0] tgt);
    if (!valid_held) in_valid <= 1'b1;
    target_hz <= tgt;
    valid_held = 1'b1;
    do @(posedge clk); while (in_stall);
    expected_settings.push_back(predict_divider_setting(tgt, bus_clock_model));
    requests_sent++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      valid_held = 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 5);
    end
  endtask

  task automatic drain_results();
    if (valid_held) begin
      in_valid <= 1'b0;
      valid_held = 1'b0;
    end
    while (expected_settings.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_bus_clock(input logic [BUS_W-1:0] hz);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= hz;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bus_clock_model = hz;
    bus_settings++;
  endtask

  task automatic test_reset_bus_clock();
    send_request(32'd0);
    send_request(32'd151);
    send_request(32'd152);
    send_request(32'd40_000_000);
    send_request(32'd26_666_666);
    send_request(32'd79_999_999);
    send_request(32'd80_000_000);
    send_request(32'hFFFF_FFFF);
    drain_results();
  endtask

  task automatic test_output_hold();
    hold_len      <= 1500;
    hold_requests <= hold_requests + 1;
    @(posedge clk);
    // keep offering while the output is held so the input backs up
    burst_left = 5;
    repeat (4) send_request(bus_clock_model + $urandom_range(0, 1000));
    send_request(32'd1_234_567);
    drain_results();
  endtask

  task automatic test_bus_clock_extremes();
    write_bus_clock(BUS_W'(1_000_000));
    send_request(32'd0);
    send_request(32'd1);
    send_request(32'd12_345);
    send_request(32'd999_999);
    send_request(32'd1_000_000);
    drain_results();
    write_bus_clock(BUS_W'(160_000_000));
    send_request(32'd304);
    send_request(32'd305);
    send_request(32'd3_000_000);
    send_request(32'd159_999_999);
    drain_results();
  endtask

  task automatic test_slow_bus_clock();
    // slowest rate truncates to zero, so a zero request meets it exactly here
    write_bus_clock(BUS_W'(300_000));
    send_request(32'd0);
    send_request(32'd1);
    send_request(32'd299_999);
    drain_results();
    write_bus_clock(BUS_W'(1));
    send_request(32'd0);
    drain_results();
  endtask

  task automatic test_random_requests();
    logic [BUS_W-1:0] bus;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1:       bus = BUS_W'(160_000_000);
        2:       bus = BUS_W'(1_000_000);
        4:       bus = BUS_W'($urandom);
        default: bus = BUS_W'($urandom_range(1_000_000, 160_000_000));
      endcase
      if (phase == 4 && $urandom_range(0, 1)) bus = '1;
      write_bus_clock(bus);
      repeat (15) send_request(pick_target(bus_clock_model));
      drain_results();
    end
  endtask

  // Receiver: random stall pattern, overridden by a counted long hold
  always @(posedge clk) begin
    if (hold_requests != hold_taken) begin
      hold_taken <= hold_requests;
      hold_left  <= hold_len;
      out_stall  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        phase_left <= $urandom_range(8, 80);
      end else begin
        phase_left <= phase_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    divider_setting_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{bypass, prescale, count_n, count_low, achieved_hz};
      if (expected_settings.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: byp=%0d pre=%0d n=%0d low=%0d hz=%0d",
                   got.bypass, got.prescale, got.count_n, got.count_low, got.achieved_hz);
      end else begin
        want = expected_settings.pop_front();
        settings_checked++;
        if (got.bypass !== want.bypass || got.prescale !== want.prescale ||
            got.count_n !== want.count_n || got.count_low !== want.count_low ||
            got.achieved_hz !== want.achieved_hz) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: exp byp=%0d pre=%0d n=%0d low=%0d hz=%0d,",
                      " got byp=%0d pre=%0d n=%0d low=%0d hz=%0d"},
                     want.bypass, want.prescale, want.count_n, want.count_low,
                     want.achieved_hz, got.bypass, got.prescale, got.count_n,
                     got.count_low, got.achieved_hz);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_settings.size());
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_bus_clock();
    test_output_hold();
    test_bus_clock_extremes();
    test_slow_bus_clock();
    test_random_requests();
    $display("%0d requests over %0d bus clock settings, %0d results checked, %0d mismatches",
             requests_sent, bus_settings, settings_checked, mismatch_count);
    $display({"covered bypass, slowest rate, zero request, exact and nearest searches,",
              " long output hold"});
    if (mismatch_count == 0 && expected_settings.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
